[sv/mrd_pkg.sv]
// Shared constants for the mesh rank decomposition block.
`default_nettype none
package mrd_pkg;
  localparam int RANK_BITS_DEF = 16;
  localparam int CELL_BITS_DEF = 20;
  localparam int CFG_ADDR_W = 2;
  localparam logic [CFG_ADDR_W-1:0] CFG_CELLS_X = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_CELLS_Y = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_CELLS_Z = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_RANKS   = 2'd3;
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANK  = 2'd1;
  localparam logic [1:0] ST_NOFIT = 2'd2;
endpackage
`default_nettype wire

[sv/mesh_rank_decomposition.sv]
// Top level: process grid search and patch extents for one rank per word.
// Work per word: 3 set-up multiplies; each px tried costs a division, each py tried under
// a dividing px a division, each fitting grid 5 multiplies and 3 divisions; the patch adds
// 5 divisions and 3 multiplies. The divider and multiplier are iterative, sized by
// M = max(CELL_BITS, RANK_BITS); error words from the rank and cell checks skip the search.
// One word at a time: a new rank is accepted only when idle; the divider and multiplier are shared.
// Reset: synchronous active-low rst_n clears control; the cell and rank-total config registers reset to 1.
`default_nettype none
module mesh_rank_decomposition #(
  parameter int RANK_BITS = mrd_pkg::RANK_BITS_DEF,
  parameter int CELL_BITS = mrd_pkg::CELL_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_tvalid,
  output logic      in_tready,
  // Fields from bit 0: rank.
  input  wire logic [((RANK_BITS+7)/8)*8-1:0] in_tdata,
  output logic      out_tvalid,
  input  wire logic out_tready,
  // Fields from bit 0: grid_x, grid_y, grid_z, begin_x, begin_y, begin_z,
  // count_x, count_y, count_z.
  output logic [((3*RANK_BITS+6*CELL_BITS+7)/8)*8-1:0] out_tdata,
  // Fields from bit 0: status.
  output logic [1:0] out_tuser,
  input  wire logic cfg_we,
  input  wire logic [mrd_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [((CELL_BITS>RANK_BITS)?CELL_BITS:RANK_BITS)-1:0] cfg_wdata
);
  localparam int RB = RANK_BITS;
  localparam int CB = CELL_BITS;
  localparam int MB = (CB > RB) ? CB : RB;
  localparam int CWA = 2*CB + MB + 2;
  localparam int CW = (CWA > 3*CB) ? CWA : 3*CB;
  localparam int LW = ((RB + 1) > CB) ? RB + 1 : CB;
  localparam int OUT_W = ((3*RB + 6*CB + 7)/8)*8;

  typedef enum logic [4:0] {
    S_IDLE, S_PRE1, S_PRE2, S_PRE3, S_PX, S_PXD, S_PY, S_PYD,
    S_M1, S_M2, S_M3, S_D1, S_D2, S_M4, S_D3, S_M5, S_CMP,
    S_C0, S_C1, S_AXD, S_AXM, S_OUT
  } state_t;

  state_t        state_r;
  logic [CB-1:0] cx_r, cy_r, cz_r;
  logic [RB-1:0] ranks_r;
  logic [RB-1:0] rank_r;
  logic [1:0]    status_r;
  logic [CW-1:0] yz_r, xz_r, xy_r;
  logic [RB:0]   px_r, py_r;
  logic [RB-1:0] remq_r, pz_r;
  logic [CW-1:0] surf_r, mx_r, best_surf_r, best_mx_r;
  logic [CB-1:0] c1_r, c2_r, c3_r;
  logic          found_r;
  logic [RB-1:0] g_r [3];
  logic [RB-1:0] coord_r [3];
  logic [CB-1:0] beg_r [3];
  logic [CB-1:0] cnt_r [3];
  logic [RB-1:0] t_r;
  logic [CB-1:0] aq_r;
  logic [RB-1:0] ar_r;
  logic [1:0]    ax_r;
  logic          wait_r;
  logic          out_tvalid_r;
  logic [1:0]    out_status_r;
  logic [RB-1:0] og_r [3];
  logic [CB-1:0] ob_r [3];
  logic [CB-1:0] oc_r [3];

  logic          div_req, mul_req, div_done, mul_done;
  logic [MB-1:0] div_n, div_q;
  logic [RB-1:0] div_d, div_r;
  logic [CW-1:0] mul_a, mul_p;
  logic [MB-1:0] mul_b;
  logic [CB-1:0] cell_ax;
  logic [CB-1:0] ceil_q;
  logic          take;
  logic [RB-1:0] coord_ax;
  logic          extra;

  assign cell_ax  = (ax_r == 2'd0) ? cx_r : ((ax_r == 2'd1) ? cy_r : cz_r);
  assign ceil_q   = CB'(div_q) + CB'(div_r != '0);
  assign coord_ax = coord_r[ax_r];
  assign extra    = coord_ax < ar_r;
  assign take     = !found_r || (surf_r < best_surf_r) ||
                    ((surf_r == best_surf_r) && (mx_r < best_mx_r));

  always_comb begin
    div_req = 1'b1;
    div_n   = '0;
    div_d   = '0;
    case (state_r)
      S_PXD: begin div_n = MB'(ranks_r); div_d = px_r[RB-1:0]; end
      S_PYD: begin div_n = MB'(remq_r);  div_d = py_r[RB-1:0]; end
      S_D1:  begin div_n = MB'(cx_r);    div_d = px_r[RB-1:0]; end
      S_D2:  begin div_n = MB'(cy_r);    div_d = py_r[RB-1:0]; end
      S_D3:  begin div_n = MB'(cz_r);    div_d = pz_r;         end
      S_C0:  begin div_n = MB'(rank_r);  div_d = g_r[0];       end
      S_C1:  begin div_n = MB'(t_r);     div_d = g_r[1];       end
      S_AXD: begin div_n = MB'(cell_ax); div_d = g_r[ax_r];    end
      default: div_req = 1'b0;
    endcase
  end

  always_comb begin
    mul_req = 1'b1;
    mul_a   = '0;
    mul_b   = '0;
    case (state_r)
      S_PRE1: begin mul_a = CW'(cy_r); mul_b = MB'(cz_r); end
      S_PRE2: begin mul_a = CW'(cx_r); mul_b = MB'(cz_r); end
      S_PRE3: begin mul_a = CW'(cx_r); mul_b = MB'(cy_r); end
      S_M1:   begin mul_a = yz_r; mul_b = MB'(px_r - 1'b1); end
      S_M2:   begin mul_a = xz_r; mul_b = MB'(py_r - 1'b1); end
      S_M3:   begin mul_a = xy_r; mul_b = MB'(pz_r - 1'b1); end
      S_M4:   begin mul_a = CW'(c1_r); mul_b = MB'(c2_r); end
      S_M5:   begin mul_a = mx_r; mul_b = MB'(c3_r); end
      S_AXM:  begin mul_a = CW'(aq_r); mul_b = MB'(coord_ax); end
      default: mul_req = 1'b0;
    endcase
  end

  mrd_div #(.NW(MB), .DW(RB)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_req && !wait_r),
    .n(div_n), .d(div_d), .done(div_done), .q(div_q), .r(div_r)
  );

  mrd_mul #(.CW(CW), .MB(MB)) u_mul (
    .clk(clk), .rst_n(rst_n), .start(mul_req && !wait_r),
    .a(mul_a), .b(mul_b), .done(mul_done), .p(mul_p)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      wait_r       <= 1'b0;
      out_tvalid_r <= 1'b0;
      cx_r         <= CB'(1);
      cy_r         <= CB'(1);
      cz_r         <= CB'(1);
      ranks_r      <= RB'(1);
      found_r      <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          mrd_pkg::CFG_CELLS_X: cx_r <= cfg_wdata[CB-1:0];
          mrd_pkg::CFG_CELLS_Y: cy_r <= cfg_wdata[CB-1:0];
          mrd_pkg::CFG_CELLS_Z: cz_r <= cfg_wdata[CB-1:0];
          mrd_pkg::CFG_RANKS:   ranks_r <= cfg_wdata[RB-1:0];
          default: ;
        endcase
      end
      if (state_r == S_OUT && (!out_tvalid_r || out_tready)) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      if ((div_req || mul_req) && !wait_r) begin
        wait_r <= 1'b1;
      end
      if (div_done || mul_done) begin
        wait_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            rank_r  <= in_tdata[RB-1:0];
            found_r <= 1'b0;
            if (in_tdata[RB-1:0] >= ranks_r) begin
              status_r <= mrd_pkg::ST_RANK;
              state_r  <= S_OUT;
            end else if (cx_r == '0 || cy_r == '0 || cz_r == '0) begin
              status_r <= mrd_pkg::ST_NOFIT;
              state_r  <= S_OUT;
            end else begin
              status_r <= mrd_pkg::ST_OK;
              state_r  <= S_PRE1;
            end
          end
        end
        S_PRE1: if (mul_done) begin yz_r <= mul_p; state_r <= S_PRE2; end
        S_PRE2: if (mul_done) begin xz_r <= mul_p; state_r <= S_PRE3; end
        S_PRE3: begin
          if (mul_done) begin
            xy_r    <= mul_p;
            px_r    <= (RB+1)'(1);
            state_r <= S_PX;
          end
        end
        S_PX: begin
          if ((px_r > (RB+1)'(ranks_r)) || (LW'(px_r) > LW'(cx_r))) begin
            if (found_r) begin
              state_r <= S_C0;
            end else begin
              status_r <= mrd_pkg::ST_NOFIT;
              state_r  <= S_OUT;
            end
          end else begin
            state_r <= S_PXD;
          end
        end
        S_PXD: begin
          if (div_done) begin
            if (div_r != '0) begin
              px_r    <= px_r + 1'b1;
              state_r <= S_PX;
            end else begin
              remq_r  <= div_q[RB-1:0];
              py_r    <= (RB+1)'(1);
              state_r <= S_PY;
            end
          end
        end
        S_PY: begin
          if ((py_r > (RB+1)'(remq_r)) || (LW'(py_r) > LW'(cy_r))) begin
            px_r    <= px_r + 1'b1;
            state_r <= S_PX;
          end else begin
            state_r <= S_PYD;
          end
        end
        S_PYD: begin
          if (div_done) begin
            pz_r <= div_q[RB-1:0];
            if (div_r != '0 || LW'(div_q[RB-1:0]) > LW'(cz_r)) begin
              py_r    <= py_r + 1'b1;
              state_r <= S_PY;
            end else begin
              state_r <= S_M1;
            end
          end
        end
        S_M1: if (mul_done) begin surf_r <= mul_p; state_r <= S_M2; end
        S_M2: if (mul_done) begin surf_r <= surf_r + mul_p; state_r <= S_M3; end
        S_M3: if (mul_done) begin surf_r <= surf_r + mul_p; state_r <= S_D1; end
        S_D1: if (div_done) begin c1_r <= ceil_q; state_r <= S_D2; end
        S_D2: if (div_done) begin c2_r <= ceil_q; state_r <= S_M4; end
        S_M4: if (mul_done) begin mx_r <= mul_p; state_r <= S_D3; end
        S_D3: if (div_done) begin c3_r <= ceil_q; state_r <= S_M5; end
        S_M5: if (mul_done) begin mx_r <= mul_p; state_r <= S_CMP; end
        S_CMP: begin
          if (take) begin
            found_r     <= 1'b1;
            best_surf_r <= surf_r;
            best_mx_r   <= mx_r;
            g_r[0]      <= px_r[RB-1:0];
            g_r[1]      <= py_r[RB-1:0];
            g_r[2]      <= pz_r;
          end
          py_r    <= py_r + 1'b1;
          state_r <= S_PY;
        end
        S_C0: begin
          if (div_done) begin
            coord_r[0] <= div_r;
            t_r        <= div_q[RB-1:0];
            state_r    <= S_C1;
          end
        end
        S_C1: begin
          if (div_done) begin
            coord_r[1] <= div_r;
            coord_r[2] <= div_q[RB-1:0];
            ax_r       <= 2'd0;
            state_r    <= S_AXD;
          end
        end
        S_AXD: begin
          if (div_done) begin
            aq_r    <= div_q[CB-1:0];
            ar_r    <= div_r;
            state_r <= S_AXM;
          end
        end
        S_AXM: begin
          if (mul_done) begin
            beg_r[ax_r] <= mul_p[CB-1:0] + (extra ? CB'(coord_ax) : CB'(ar_r));
            cnt_r[ax_r] <= aq_r + CB'(extra);
            if (ax_r == 2'd2) begin
              state_r <= S_OUT;
            end else begin
              ax_r    <= ax_r + 1'b1;
              state_r <= S_AXD;
            end
          end
        end
        S_OUT: begin
          if (!out_tvalid_r || out_tready) begin
            out_status_r <= status_r;
            for (int i = 0; i < 3; i++) begin
              og_r[i] <= (status_r == mrd_pkg::ST_OK) ? g_r[i] : '0;
              ob_r[i] <= (status_r == mrd_pkg::ST_OK) ? beg_r[i] : '0;
              oc_r[i] <= (status_r == mrd_pkg::ST_OK) ? cnt_r[i] : '0;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = OUT_W'({oc_r[2], oc_r[1], oc_r[0], ob_r[2], ob_r[1], ob_r[0],
                              og_r[2], og_r[1], og_r[0]});

`ifndef NO_ASSERTIONS
  a_unit_done: assert property (@(posedge clk) disable iff (!rst_n)
    (div_done || mul_done) |-> wait_r)
    else $error("arithmetic unit finished without a pending request");
  a_one_unit: assert property (@(posedge clk) disable iff (!rst_n)
    !(div_req && mul_req))
    else $error("divider and multiplier requested together");
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && out_status_r != mrd_pkg::ST_OK) |-> (og_r[0] == '0 && oc_r[0] == '0))
    else $error("error word carries nonzero fields");
  a_grid_ok: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) && out_status_r == mrd_pkg::ST_OK |->
      ((3*RB)'(og_r[0]) * (3*RB)'(og_r[1]) * (3*RB)'(og_r[2]) == (3*RB)'(ranks_r)))
    else $error("chosen grid does not multiply to the rank total");
`endif
endmodule
`default_nettype wire

[sv/mrd_div.sv]
// Iterative restoring divider, one quotient bit per cycle.
`default_nettype none
module mrd_div #(
  parameter int NW = mrd_pkg::CELL_BITS_DEF,
  parameter int DW = mrd_pkg::RANK_BITS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [NW-1:0] n,
  input  wire logic [DW-1:0] d,
  output logic               done,
  output logic [NW-1:0]      q,
  output logic [DW-1:0]      r
);
  localparam int CNT_W = $clog2(NW);
  logic [NW-1:0]    quo_r;
  logic [DW-1:0]    rem_r;
  logic [DW-1:0]    d_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DW:0]      trial;
  logic             fit;

  assign trial = {rem_r, quo_r[NW-1]};
  assign fit   = trial >= {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        quo_r  <= n;
        rem_r  <= '0;
        d_r    <= d;
      end else if (busy_r) begin
        rem_r <= fit ? DW'(trial - {1'b0, d_r}) : trial[DW-1:0];
        quo_r <= {quo_r[NW-2:0], fit};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(NW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign q    = quo_r;
  assign r    = rem_r;
endmodule
`default_nettype wire

[sv/mrd_mul.sv]
// Shift-and-add multiplier, one multiplier bit per cycle.
`default_nettype none
module mrd_mul #(
  parameter int CW = 64,
  parameter int MB = mrd_pkg::CELL_BITS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [CW-1:0] a,
  input  wire logic [MB-1:0] b,
  output logic               done,
  output logic [CW-1:0]      p
);
  localparam int CNT_W = $clog2(MB);
  logic [CW-1:0]    acc_r;
  logic [CW-1:0]    a_r;
  logic [MB-1:0]    b_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        acc_r  <= '0;
        a_r    <= a;
        b_r    <= b;
      end else if (busy_r) begin
        if (b_r[0]) begin
          acc_r <= acc_r + a_r;
        end
        a_r   <= {a_r[CW-2:0], 1'b0};
        b_r   <= {1'b0, b_r[MB-1:1]};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(MB - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign p    = acc_r;
endmodule
`default_nettype wire
